[rtl/beg_pkg.sv]
package beg_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int CMD_W           = 3;
    localparam int TIME_W          = 24;
    localparam int VAL_W           = 24;
    localparam int TIME_STEP       = 50;
    localparam int ONE_Q16         = 65536;
    localparam int DIV_STEPS       = 24;

    localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TRIG   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [TIME_W-1:0]       seg_delta;
        logic signed [VAL_W-1:0] point_value;
        logic [TIME_W-1:0]       eval_time;
    } t_beg_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic [TIME_W-1:0]       out_time;
        logic                    last;
    } t_beg_out;

    typedef struct packed {
        logic [TIME_W-1:0]       bp_time;
        logic signed [VAL_W-1:0] bp_value;
    } t_beg_entry;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_EV_RD,
        S_EV_CMP,
        S_EV_MUL,
        S_EV_ABS,
        S_EV_DSTART,
        S_EV_DWAIT,
        S_EV_OUT,
        S_TR_RD0,
        S_TR_OUT0,
        S_TR_RD1,
        S_TR_OUT1,
        S_TK_RD0,
        S_TK_CAP,
        S_TK_RD1,
        S_TK_OUT
    } t_beg_state;

    function automatic t_beg_entry reset_entry(input logic [1:0] idx);
        t_beg_entry e;
        e.bp_time  = '0;
        e.bp_value = '0;
        case (idx)
            2'd1: begin
                e.bp_time  = TIME_W'(TIME_STEP);
                e.bp_value = VAL_W'(ONE_Q16);
            end
            2'd2: begin
                e.bp_time  = TIME_W'(2 * TIME_STEP);
            end
            default: begin
                e.bp_time  = '0;
            end
        endcase
        return e;
    endfunction

endpackage

[rtl/beg_mem.sv]
module beg_mem #(
    parameter int TABLE_DEPTH = beg_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   i_waddr,
    input  beg_pkg::t_beg_entry              i_wdata,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   i_raddr,
    output beg_pkg::t_beg_entry              o_rdata
);

    beg_pkg::t_beg_entry r_mem [TABLE_DEPTH];
    beg_pkg::t_beg_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/beg_div.sv]
module beg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [2*beg_pkg::TIME_W-1:0]  i_dividend,
    input  logic [beg_pkg::TIME_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [beg_pkg::TIME_W-1:0]    o_quot
);

    localparam int W     = beg_pkg::TIME_W;
    localparam int CNT_W = $clog2(beg_pkg::DIV_STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_q;
    logic [W-1:0]     r_div;

    logic [W:0]       shifted;
    logic [W+1:0]     trial;

    assign shifted = {r_rem, r_q[W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(beg_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[2*W-1:W];
            r_q   <= i_dividend[W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!trial[W+1]) begin
                r_rem <= trial[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[rtl/breakpoint_envelope_generator.sv]
// channel   dir  handshake                 payload
// in        in   i_in_valid / o_in_stall    i_in_data  (beg_pkg::t_beg_in)
// out       out  o_out_valid / i_out_stall  o_out_data (beg_pkg::t_beg_out)
//
// start and append finish in the dispatch state; trigger reads two table entries, tick two when a segment remains
// evaluate scans breakpoints one at a time through the single table read port,
// then multiplies and runs the 24-step serial divide unless clamped or flat
// after reset the first min(3, TABLE_DEPTH) table entries are written, one a cycle
// a result sits in an output register; a downstream stall holds the sequencer
module breakpoint_envelope_generator #(
    parameter int TABLE_DEPTH = beg_pkg::TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  beg_pkg::t_beg_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output beg_pkg::t_beg_out o_out_data
);

    localparam int TW    = beg_pkg::TIME_W;
    localparam int VW    = beg_pkg::VAL_W;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SEG_W = IDX_W + 1;
    localparam int LAST_RST = (TABLE_DEPTH > 2) ? 2 : TABLE_DEPTH - 1;
    localparam logic [IDX_W-1:0] LAST_RST_IDX = IDX_W'(LAST_RST);
    localparam logic [IDX_W-1:0] LAST_MAX     = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [SEG_W-1:0] SEG_MAX      = SEG_W'(TABLE_DEPTH);
    localparam logic [TW-1:0]    RUN_RST      = TW'(LAST_RST * beg_pkg::TIME_STEP);

    beg_pkg::t_beg_state r_state, n_state;
    beg_pkg::t_beg_in    r_item;
    logic [IDX_W-1:0]    r_last, n_last;
    logic [SEG_W-1:0]    r_seg, n_seg;
    logic [TW-1:0]       r_run, n_run;
    logic [IDX_W-1:0]    r_ptr, n_ptr;
    beg_pkg::t_beg_entry r_prev, n_prev;
    beg_pkg::t_beg_entry r_cur, n_cur;
    logic signed [2*TW:0] r_prod;
    logic [2*TW-1:0]     r_mag;
    logic                r_neg;
    logic signed [VW-1:0] r_res, n_res;
    logic                r_out_valid;
    beg_pkg::t_beg_out   r_out, n_out;

    logic                in_xfer;
    logic                out_free;
    logic                out_load;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    beg_pkg::t_beg_entry mem_wdata;
    beg_pkg::t_beg_entry rd_data;
    logic                div_start;
    logic                div_done;
    logic [TW-1:0]       div_quot;

    logic                scan_more;
    logic                clamp;
    logic                flat;
    logic [SEG_W-1:0]    seg_inc;
    logic                tick_hit;
    logic [TW:0]         run_sum;
    logic [TW-1:0]       run_sat;
    logic [TW-1:0]       diff_t;
    logic signed [VW:0]  diff_v;
    logic signed [2*TW+1:0] prod_full;
    logic [2*TW:0]       prod_abs;
    logic [VW+1:0]       q_signed;
    logic [VW+1:0]       interp;

    assign in_xfer  = i_in_valid && (r_state == beg_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign scan_more = (r_ptr < r_last) && (rd_data.bp_time < r_item.eval_time);
    assign clamp     = (r_ptr == '0) || (r_item.eval_time >= r_run);
    assign flat      = (r_cur.bp_time == r_prev.bp_time);
    assign seg_inc   = (r_seg < SEG_MAX) ? r_seg + 1'b1 : r_seg;
    assign tick_hit  = (seg_inc != '0) && (seg_inc <= {1'b0, r_last});
    assign run_sum   = {1'b0, r_run} + {1'b0, r_item.seg_delta};
    assign run_sat   = run_sum[TW] ? {TW{1'b1}} : run_sum[TW-1:0];

    assign diff_t    = r_item.eval_time - r_prev.bp_time;
    assign diff_v    = {r_cur.bp_value[VW-1], r_cur.bp_value}
                     - {r_prev.bp_value[VW-1], r_prev.bp_value};
    assign prod_full = $signed({1'b0, diff_t}) * diff_v;
    assign prod_abs  = r_prod[2*TW] ? -r_prod : r_prod;
    assign q_signed  = r_neg ? -{2'b00, div_quot} : {2'b00, div_quot};
    assign interp    = {{2{r_prev.bp_value[VW-1]}}, r_prev.bp_value} + q_signed;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            beg_pkg::S_INIT: begin
                if (r_ptr == LAST_RST_IDX) begin
                    n_state = beg_pkg::S_IDLE;
                end
            end
            beg_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = beg_pkg::S_DISPATCH;
                end
            end
            beg_pkg::S_DISPATCH: begin
                unique case (r_item.cmd)
                    beg_pkg::CMD_EVAL: n_state = beg_pkg::S_EV_RD;
                    beg_pkg::CMD_TRIG: n_state = beg_pkg::S_TR_RD0;
                    beg_pkg::CMD_TICK: begin
                        n_state = tick_hit ? beg_pkg::S_TK_RD0 : beg_pkg::S_IDLE;
                    end
                    default: n_state = beg_pkg::S_IDLE;
                endcase
            end
            beg_pkg::S_EV_RD: n_state = beg_pkg::S_EV_CMP;
            beg_pkg::S_EV_CMP: begin
                if (scan_more) begin
                    n_state = beg_pkg::S_EV_RD;
                end else if (clamp) begin
                    n_state = beg_pkg::S_EV_OUT;
                end else begin
                    n_state = beg_pkg::S_EV_MUL;
                end
            end
            beg_pkg::S_EV_MUL: begin
                n_state = flat ? beg_pkg::S_EV_OUT : beg_pkg::S_EV_ABS;
            end
            beg_pkg::S_EV_ABS:    n_state = beg_pkg::S_EV_DSTART;
            beg_pkg::S_EV_DSTART: n_state = beg_pkg::S_EV_DWAIT;
            beg_pkg::S_EV_DWAIT: begin
                if (div_done) begin
                    n_state = beg_pkg::S_EV_OUT;
                end
            end
            beg_pkg::S_EV_OUT: begin
                if (out_free) begin
                    n_state = beg_pkg::S_IDLE;
                end
            end
            beg_pkg::S_TR_RD0: n_state = beg_pkg::S_TR_OUT0;
            beg_pkg::S_TR_OUT0: begin
                if (out_free) begin
                    n_state = beg_pkg::S_TR_RD1;
                end
            end
            beg_pkg::S_TR_RD1: n_state = beg_pkg::S_TR_OUT1;
            beg_pkg::S_TR_OUT1: begin
                if (out_free) begin
                    n_state = beg_pkg::S_IDLE;
                end
            end
            beg_pkg::S_TK_RD0: n_state = beg_pkg::S_TK_CAP;
            beg_pkg::S_TK_CAP: n_state = beg_pkg::S_TK_RD1;
            beg_pkg::S_TK_RD1: n_state = beg_pkg::S_TK_OUT;
            beg_pkg::S_TK_OUT: begin
                if (out_free) begin
                    n_state = beg_pkg::S_IDLE;
                end
            end
            default: n_state = beg_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_last    = r_last;
        n_seg     = r_seg;
        n_run     = r_run;
        n_ptr     = r_ptr;
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_res     = r_res;
        n_out     = r_out;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = beg_pkg::reset_entry(2'(r_ptr));
        div_start = 1'b0;
        unique case (r_state)
            beg_pkg::S_INIT: begin
                mem_we = 1'b1;
                n_ptr  = r_ptr + 1'b1;
            end
            beg_pkg::S_DISPATCH: begin
                unique case (r_item.cmd)
                    beg_pkg::CMD_START: begin
                        mem_we             = 1'b1;
                        mem_waddr          = '0;
                        mem_wdata.bp_time  = '0;
                        mem_wdata.bp_value = r_item.point_value;
                        n_last             = '0;
                        n_run              = '0;
                    end
                    beg_pkg::CMD_APPEND: begin
                        if (r_last != LAST_MAX) begin
                            mem_we             = 1'b1;
                            mem_waddr          = r_last + 1'b1;
                            mem_wdata.bp_time  = run_sat;
                            mem_wdata.bp_value = r_item.point_value;
                            n_last             = r_last + 1'b1;
                            n_run              = run_sat;
                        end
                    end
                    beg_pkg::CMD_EVAL: begin
                        n_ptr = '0;
                    end
                    beg_pkg::CMD_TRIG: begin
                        n_ptr = '0;
                        n_seg = SEG_W'(1);
                    end
                    beg_pkg::CMD_TICK: begin
                        n_seg = seg_inc;
                        n_ptr = IDX_W'(seg_inc - 1'b1);
                    end
                    default: begin
                        n_ptr = r_ptr;
                    end
                endcase
            end
            beg_pkg::S_EV_CMP: begin
                if (scan_more) begin
                    n_prev = rd_data;
                    n_ptr  = r_ptr + 1'b1;
                end else begin
                    n_cur = rd_data;
                    n_res = rd_data.bp_value;
                end
            end
            beg_pkg::S_EV_MUL: begin
                n_res = r_cur.bp_value;
            end
            beg_pkg::S_EV_DSTART: begin
                div_start = 1'b1;
            end
            beg_pkg::S_EV_DWAIT: begin
                if (div_done) begin
                    n_res = interp[VW-1:0];
                end
            end
            beg_pkg::S_EV_OUT: begin
                out_load        = out_free;
                n_out.out_value = r_res;
                n_out.out_time  = '0;
                n_out.last      = 1'b1;
            end
            beg_pkg::S_TR_OUT0: begin
                out_load        = out_free;
                n_out.out_value = rd_data.bp_value;
                n_out.out_time  = '0;
                n_out.last      = 1'b0;
                if (out_free) begin
                    n_ptr = IDX_W'(1);
                end
            end
            beg_pkg::S_TR_OUT1: begin
                out_load        = out_free;
                n_out.out_value = rd_data.bp_value;
                n_out.out_time  = rd_data.bp_time;
                n_out.last      = 1'b1;
            end
            beg_pkg::S_TK_CAP: begin
                n_prev = rd_data;
                n_ptr  = r_ptr + 1'b1;
            end
            beg_pkg::S_TK_OUT: begin
                out_load        = out_free;
                n_out.out_value = rd_data.bp_value;
                n_out.out_time  = rd_data.bp_time - r_prev.bp_time;
                n_out.last      = 1'b1;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
        if (!out_load) begin
            n_out = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= beg_pkg::S_INIT;
            r_last      <= LAST_RST_IDX;
            r_seg       <= '0;
            r_run       <= RUN_RST;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_seg   <= n_seg;
            r_run   <= n_run;
            r_ptr   <= n_ptr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_data;
        end
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_res  <= n_res;
        r_out  <= n_out;
        if (r_state == beg_pkg::S_EV_MUL) begin
            r_prod <= prod_full[2*TW:0];
        end
        if (r_state == beg_pkg::S_EV_ABS) begin
            r_mag <= prod_abs[2*TW-1:0];
            r_neg <= r_prod[2*TW];
        end
    end

    beg_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ptr),
        .o_rdata (rd_data)
    );

    beg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_cur.bp_time - r_prev.bp_time),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_in_stall  = (r_state != beg_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/beg_chk.sv]
module beg_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input beg_pkg::t_beg_in  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input beg_pkg::t_beg_out o_out_data
);

    // a transfer in keeps the block busy on the next cycle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while block still idle");

    // the table load after reset holds off input
    a_init_stall: assert property (@(posedge i_clk)
        ($past(!i_rst_n) && i_rst_n) |-> o_in_stall)
        else $error("input open during table load");

    // a new result only appears while an item is being worked on
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in progress");

    // the only non-final result is the trigger start value with zero duration
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> (o_out_data.out_time == '0))
        else $error("non-final result with nonzero duration");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind breakpoint_envelope_generator beg_chk u_beg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
